[hdl/cwc_pkg.sv]
`default_nettype none
package cwc_pkg;
    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned RADIUS_W        = 31;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd3;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 31'd65536;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_DOT,
        ST_SEL,
        ST_ABS,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_be_state;
endpackage
`default_nettype wire

[hdl/cwc_front.sv]
`default_nettype none
// Front end: height test and the differences of one wall.
module cwc_front
    import cwc_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_x1,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_z1,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_x2,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_z2,
    input  wire logic                          i_last_wall,
    input  wire logic        [RADIUS_W-1:0]    i_radius,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [COORD_WIDTH:0]        o_abx,
    output logic signed [COORD_WIDTH:0]        o_abz,
    output logic signed [COORD_WIDTH:0]        o_apx,
    output logic signed [COORD_WIDTH:0]        o_apz,
    output logic signed [COORD_WIDTH:0]        o_bpx,
    output logic signed [COORD_WIDTH:0]        o_bpz,
    output logic                               o_in_range,
    output logic                               o_last
);
    localparam int unsigned HW = COORD_WIDTH + 3;
    logic signed [HW-1:0] h, rad_ext, zmin, zmax;
    logic r_valid;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;

    // height overlap against raw wall z
    always_comb begin
        h       = HW'(i_pos_y) - HW'(i_center_y);
        rad_ext = HW'(signed'({1'b0, i_radius}));
        zmin    = (i_wall_z1 < i_wall_z2) ? HW'(i_wall_z1) : HW'(i_wall_z2);
        zmax    = (i_wall_z1 < i_wall_z2) ? HW'(i_wall_z2) : HW'(i_wall_z1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            o_abx      <= (COORD_WIDTH+1)'(i_wall_x2) - (COORD_WIDTH+1)'(i_wall_x1);
            o_abz      <= (COORD_WIDTH+1)'(i_wall_z2) - (COORD_WIDTH+1)'(i_wall_z1);
            o_apx      <= (COORD_WIDTH+1)'(i_pos_x) - (COORD_WIDTH+1)'(i_wall_x1);
            o_apz      <= (COORD_WIDTH+1)'(i_pos_z) - (COORD_WIDTH+1)'(i_wall_z1);
            o_bpx      <= (COORD_WIDTH+1)'(i_pos_x) - (COORD_WIDTH+1)'(i_wall_x2);
            o_bpz      <= (COORD_WIDTH+1)'(i_pos_z) - (COORD_WIDTH+1)'(i_wall_z2);
            o_in_range <= !((h + rad_ext < zmin) || (h - rad_ext > zmax));
            o_last     <= i_last_wall;
        end
    end
endmodule
`default_nettype wire

[hdl/cwc_back.sv]
`default_nettype none
// Back end: sequenced squared-distance test, hit accumulation and output stage.
module cwc_back
    import cwc_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH:0]   i_abx,
    input  wire logic signed [COORD_WIDTH:0]   i_abz,
    input  wire logic signed [COORD_WIDTH:0]   i_apx,
    input  wire logic signed [COORD_WIDTH:0]   i_apz,
    input  wire logic signed [COORD_WIDTH:0]   i_bpx,
    input  wire logic signed [COORD_WIDTH:0]   i_bpz,
    input  wire logic                          i_in_range,
    input  wire logic                          i_last,
    input  wire logic        [RADIUS_W-1:0]    i_radius,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_collided
);
    localparam int unsigned DW   = COORD_WIDTH + 1;     // difference width
    localparam int unsigned PW   = 2 * DW;              // product width
    localparam int unsigned SW   = PW + 1;              // sum of two products
    localparam int unsigned QW   = 2 * SW;              // square of a sum
    localparam int unsigned RW   = 2 * RADIUS_W;        // r squared
    localparam int unsigned HALF = (SW + 1) / 2;        // digit of the wide multiply
    localparam int unsigned LW   = 2 * HALF;            // padded operand width
    localparam int unsigned AW   = 2 * LW;              // wide product accumulator

    t_be_state r_state, n_state;
    logic signed [DW-1:0] r_abx, r_abz, r_apx, r_apz, r_bpx, r_bpz;
    logic r_in_range, r_last, r_hit_acc, r_out_valid, r_out_hit;
    logic signed [SW-1:0] r_len, r_dot, r_cr;
    logic [SW-1:0] r_dist, r_cmag;
    logic r_mid;
    logic [1:0] r_k;
    logic [AW-1:0] r_lhs, r_rhs;
    logic signed [PW-1:0] r_p0, r_p1;
    logic [RW-1:0] r_r2;
    logic signed [DW-1:0] near_x, near_z;
    logic signed [PW-1:0] sq_x, sq_z;
    logic [LW-1:0] cm_ext, r2_ext, len_ext, pp_l, pp_r;
    logic [HALF-1:0] dg_a, dg_b, dg_c, dg_d;
    logic [AW-1:0] sh_l, sh_r;
    logic wall_hit, degenerate, take, busy_done;

    assign take      = i_valid && (r_state == ST_IDLE);
    assign o_stall   = r_state != ST_IDLE;
    assign busy_done = !(r_out_valid && i_stall);
    assign o_valid   = r_out_valid;
    assign o_collided = r_out_hit;

    // wall counts as degenerate when len * 2^23 <= 2^(2*FRAC_BITS)
    assign degenerate = (QW'(unsigned'(r_len)) << 23) <= (QW'(1) << (2 * FRAC_BITS));

    // squared distance to the clamped endpoint
    always_comb begin
        near_x = (r_dot <= 0) ? r_apx : r_bpx;
        near_z = (r_dot <= 0) ? r_apz : r_bpz;
        sq_x   = near_x * near_x;
        sq_z   = near_z * near_z;
    end

    // one digit pair of cr*cr and r2*len per step
    always_comb begin
        cm_ext  = LW'(r_cmag);
        r2_ext  = LW'(r_r2);
        len_ext = LW'(unsigned'(r_len));
        dg_a = r_k[1] ? cm_ext[LW-1:HALF] : cm_ext[HALF-1:0];
        dg_b = r_k[0] ? cm_ext[LW-1:HALF] : cm_ext[HALF-1:0];
        dg_c = r_k[1] ? r2_ext[LW-1:HALF] : r2_ext[HALF-1:0];
        dg_d = r_k[0] ? len_ext[LW-1:HALF] : len_ext[HALF-1:0];
        pp_l = dg_a * dg_b;
        pp_r = dg_c * dg_d;
        case (r_k)
            2'd0: begin
                sh_l = AW'(pp_l);
                sh_r = AW'(pp_r);
            end
            2'd3: begin
                sh_l = AW'(pp_l) << (2 * HALF);
                sh_r = AW'(pp_r) << (2 * HALF);
            end
            default: begin
                sh_l = AW'(pp_l) << HALF;
                sh_r = AW'(pp_r) << HALF;
            end
        endcase
    end

    // final compare
    always_comb begin
        if (r_mid) wall_hit = r_lhs < r_rhs;
        else       wall_hit = QW'(r_dist) < QW'(r_r2);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (take) n_state = ST_LEN;
            ST_LEN:  n_state = ST_DOT;
            ST_DOT:  n_state = ST_SEL;
            ST_SEL:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_MUL;
            ST_MUL:  if (r_k == 2'd3) n_state = ST_CMP;
            ST_CMP:  if (busy_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit_acc   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            if (r_state == ST_CMP && busy_done) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_hit_acc   <= 1'b0;
                end else begin
                    r_hit_acc <= r_hit_acc ||
                                 (r_in_range && !degenerate && wall_hit);
                end
            end
        end
    end

    // datapath steps
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    r_abx <= i_abx; r_abz <= i_abz;
                    r_apx <= i_apx; r_apz <= i_apz;
                    r_bpx <= i_bpx; r_bpz <= i_bpz;
                    r_in_range <= i_in_range;
                    r_last     <= i_last;
                    r_p0 <= i_abx * i_abx;
                    r_p1 <= i_abz * i_abz;
                    r_r2 <= RW'(i_radius) * RW'(i_radius);
                end
            end
            ST_LEN: begin
                r_len <= SW'(r_p0) + SW'(r_p1);
                r_p0  <= r_apx * r_abx;
                r_p1  <= r_apz * r_abz;
            end
            ST_DOT: begin
                r_dot <= SW'(r_p0) + SW'(r_p1);
                r_p0  <= r_apx * r_abz;
                r_p1  <= r_apz * r_abx;
            end
            ST_SEL: begin
                r_cr   <= SW'(r_p0) - SW'(r_p1);
                r_dist <= SW'(unsigned'(sq_x)) + SW'(unsigned'(sq_z));
                r_mid  <= !((r_dot <= 0) || (r_dot >= r_len));
            end
            ST_ABS: begin
                r_cmag <= (r_cr < 0) ? unsigned'(-r_cr) : unsigned'(r_cr);
                r_k    <= '0;
                r_lhs  <= '0;
                r_rhs  <= '0;
            end
            ST_MUL: begin
                r_lhs <= r_lhs + sh_l;
                r_rhs <= r_rhs + sh_r;
                r_k   <= r_k + 2'd1;
            end
            ST_CMP: begin
                if (busy_done && r_last) begin
                    r_out_hit <= r_hit_acc || (r_in_range && !degenerate && wall_hit);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[hdl/circle_wall_collision_test.sv]
// An accepted item passes the front register, then the back end's states LEN, DOT,
// SEL, ABS, MUL and CMP before the result of a query's last wall, longer while the result waits under output stall.
// The back end takes a new wall only once it is idle again, after its multiply steps.
// The front end registers the height test and differences; one item may wait there.
// Reset (i_rst_n low, synchronous) clears handshakes and the hit accumulator;
// radius returns to 1.0 and the map center to zero.
`default_nettype none
module circle_wall_collision_test
    import cwc_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_x1,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_z1,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_x2,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_z2,
    input  wire logic                          i_last_wall,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_collided,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);
    logic [RADIUS_W-1:0]           r_radius;
    logic signed [COORD_WIDTH-1:0] r_center_y;
    logic f_valid, b_stall, f_in_range, f_last;
    logic signed [COORD_WIDTH:0] f_abx, f_abz, f_apx, f_apz, f_bpx, f_bpz;

    assign o_cfg_ready = 1'b1;

    // configuration registers (center x/z cancel in every difference, writes are dropped)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RESET;
            r_center_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS:   r_radius   <= i_cfg_data[RADIUS_W-1:0];
                REG_CENTER_X: ;
                REG_CENTER_Y: r_center_y <= COORD_WIDTH'(signed'(i_cfg_data));
                REG_CENTER_Z: ;
                default: ;
            endcase
        end
    end

    cwc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_wall_x1(i_wall_x1), .i_wall_z1(i_wall_z1),
        .i_wall_x2(i_wall_x2), .i_wall_z2(i_wall_z2),
        .i_last_wall(i_last_wall), .i_radius(r_radius), .i_center_y(r_center_y),
        .o_valid(f_valid), .i_stall(b_stall),
        .o_abx(f_abx), .o_abz(f_abz), .o_apx(f_apx), .o_apz(f_apz),
        .o_bpx(f_bpx), .o_bpz(f_bpz), .o_in_range(f_in_range), .o_last(f_last)
    );

    cwc_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_stall(b_stall),
        .i_abx(f_abx), .i_abz(f_abz), .i_apx(f_apx), .i_apz(f_apz),
        .i_bpx(f_bpx), .i_bpz(f_bpz), .i_in_range(f_in_range), .i_last(f_last),
        .i_radius(r_radius),
        .o_valid(o_valid), .i_stall(i_stall), .o_collided(o_collided)
    );

    // config port always accepts a write
    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port not ready");
    // front holds its item while the back end is busy
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && b_stall) |=> f_valid)
        else $error("front item dropped under back stall");
    // no result while reset was asserted
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
    import cwc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam longint ONE = 64'sd65536;
    localparam int ITEM_TARGET = 850;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [159:0] wide_t;

    typedef struct {
        coord_t px, py, pz, x1, z1, x2, z2;
        logic   last;
    } wall_item_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall, o_collided;
    coord_t i_pos_x, i_pos_y, i_pos_z, i_wall_x1, i_wall_z1, i_wall_x2, i_wall_z2;
    logic i_last_wall;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    circle_wall_collision_test DUT (.*);

    // shadow registers and hit accumulator
    logic [RADIUS_W-1:0] sh_radius;
    longint sh_cx, sh_cy, sh_cz;
    bit hit_acc;

    wall_item_t pending_q[$];
    bit collided_q[$];
    wall_item_t offered;
    int errors, accepted_cnt, queries_seen, hits_seen, burst_left, gap_left;
    longint cycle_cnt;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // exact circle vs segment test in wide integers
    function automatic bit wall_hits(wall_item_t w);
        longint h, r, zmin, zmax;
        wide_t abx, abz, apx, apz, bpx, bpz, len2, r2, dot, crs;
        h = longint'(w.py) - sh_cy;
        r = longint'(sh_radius);
        zmin = (w.z1 < w.z2) ? longint'(w.z1) : longint'(w.z2);
        zmax = (w.z1 < w.z2) ? longint'(w.z2) : longint'(w.z1);
        if (h + r < zmin || h - r > zmax) return 1'b0;
        abx = wide_t'(w.x2) - wide_t'(w.x1);
        abz = wide_t'(w.z2) - wide_t'(w.z1);
        apx = wide_t'(w.px) - wide_t'(w.x1);
        apz = wide_t'(w.pz) - wide_t'(w.z1);
        bpx = wide_t'(w.px) - wide_t'(w.x2);
        bpz = wide_t'(w.pz) - wide_t'(w.z2);
        len2 = abx * abx + abz * abz;
        // short segment: L * 2^23 <= 2^32
        if (len2 <= 512) return 1'b0;
        r2 = wide_t'(r) * wide_t'(r);
        dot = apx * abx + apz * abz;
        if (dot <= 0) return (apx * apx + apz * apz) < r2;
        if (dot >= len2) return (bpx * bpx + bpz * bpz) < r2;
        crs = apx * abz - apz * abx;
        return (crs * crs) < (r2 * len2);
    endfunction

    function automatic void absorb_wall(wall_item_t w);
        bit h;
        h = wall_hits(w);
        if (w.last) begin
            collided_q.push_back(hit_acc | h);
            hit_acc = 1'b0;
        end else begin
            hit_acc = hit_acc | h;
        end
    endfunction

    function automatic wall_item_t mk(longint px, longint py, longint pz, longint x1,
                                      longint z1, longint x2, longint z2, bit last);
        wall_item_t w;
        w.px = coord_t'(px); w.py = coord_t'(py); w.pz = coord_t'(pz);
        w.x1 = coord_t'(x1); w.z1 = coord_t'(z1);
        w.x2 = coord_t'(x2); w.z2 = coord_t'(z2);
        w.last = last;
        return w;
    endfunction

    function automatic longint rs(int n);
        return longint'($urandom_range(0, (1 << (n + 1)) - 1)) - (longint'(1) << n);
    endfunction

    // mostly walls near the player with matching heights, some raw noise
    function automatic wall_item_t rand_wall(bit last);
        wall_item_t w;
        int sc;
        if ($urandom_range(0, 9) == 0) begin
            w.px = $urandom; w.py = $urandom; w.pz = $urandom;
            w.x1 = $urandom; w.z1 = $urandom; w.x2 = $urandom; w.z2 = $urandom;
        end else begin
            sc = $urandom_range(12, 20);
            w.px = coord_t'(rs(28)); w.pz = coord_t'(rs(20));
            w.x1 = coord_t'(longint'(w.px) + rs(sc));
            w.z1 = coord_t'(longint'(w.pz) + rs(sc));
            w.x2 = coord_t'(longint'(w.px) + rs(sc));
            w.z2 = coord_t'(longint'(w.pz) + rs(sc));
            w.py = coord_t'(sh_cy + longint'(w.z1) + rs(sc));
        end
        w.last = last;
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:   sh_radius = data[RADIUS_W-1:0];
            REG_CENTER_X: sh_cx = longint'(signed'(data));
            REG_CENTER_Y: sh_cy = longint'(signed'(data));
            REG_CENTER_Z: sh_cz = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_valid || collided_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                absorb_wall(offered);
                accepted_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left == 0 && gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    wall_item_t nx;
                    nx = pending_q.pop_front();
                    burst_left--;
                    offered <= nx;
                    i_valid <= 1'b1;
                    i_pos_x <= nx.px; i_pos_y <= nx.py; i_pos_z <= nx.pz;
                    i_wall_x1 <= nx.x1; i_wall_z1 <= nx.z1;
                    i_wall_x2 <= nx.x2; i_wall_z2 <= nx.z2;
                    i_last_wall <= nx.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with two long hold-offs
    always @(posedge i_clk) begin
        int mode;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            cycle_cnt = 0;
            mode = 0;
        end else begin
            cycle_cnt++;
            if (cycle_cnt % 64 == 0) mode = $urandom_range(0, 2);
            if ((cycle_cnt >= 2000 && cycle_cnt < 2300) ||
                (cycle_cnt >= 6000 && cycle_cnt < 6400))
                i_stall <= 1'b1;
            else if (mode == 0)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(0, 9) < (mode == 1 ? 3 : 7));
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (collided_q.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = collided_q.pop_front();
                queries_seen++;
                if (o_collided) hits_seen++;
                if (o_collided !== want)
                    report_mismatch($sformatf("collided got %b want %b", o_collided, want));
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("testbench failed");
        $finish;
    end

    initial begin
        int per_phase, n;
        errors = 0; accepted_cnt = 0; queries_seen = 0; hits_seen = 0;
        hit_acc = 1'b0;
        sh_radius = RADIUS_RESET; sh_cx = 0; sh_cy = 0; sh_cz = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0; i_stall <= 1'b0; i_last_wall <= 1'b0;
        i_pos_x <= '0; i_pos_y <= '0; i_pos_z <= '0;
        i_wall_x1 <= '0; i_wall_z1 <= '0; i_wall_x2 <= '0; i_wall_z2 <= '0;
        i_cfg_valid <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walls at reset settings (radius 1.0, center zero)
        pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
        pending_q.push_back(mk(-64'sh80000000, -64'sh80000000, -64'sh80000000,
                               -64'sh80000000, -64'sh80000000, -64'sh80000000,
                               -64'sh80000000, 1));
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1));          // zero-length wall
        pending_q.push_back(mk(0, 0, 0, 0, 0, 16, 16, 1));        // just too short
        pending_q.push_back(mk(0, 0, 0, 0, 0, 23, 0, 1));         // just long enough
        pending_q.push_back(mk(ONE * 3 / 2, 0, 0, 2 * ONE, 0, 5 * ONE, 0, 1)); // before A
        pending_q.push_back(mk(0, 0, 0, -5 * ONE, 0, -2 * ONE, 0, 1));         // past B
        pending_q.push_back(mk(0, 0, 0, -5 * ONE, ONE / 2, 5 * ONE, ONE / 2, 1));
        pending_q.push_back(mk(0, 0, 0, -5 * ONE, ONE, 5 * ONE, ONE, 1)); // distance = r
        pending_q.push_back(mk(0, 10 * ONE, 0, -5 * ONE, ONE / 2, 5 * ONE, ONE / 2, 1));
        pending_q.push_back(mk(0, -10 * ONE, 0, -5 * ONE, ONE / 2, 5 * ONE, ONE / 2, 1));
        pending_q.push_back(mk(0, 0, 0, -5 * ONE, 0, -2 * ONE, 0, 0));
        pending_q.push_back(mk(0, 0, 0, -5 * ONE, ONE / 2, 5 * ONE, ONE / 2, 0));
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1));          // hit in middle of query
        pending_q.push_back(mk(32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa,
                               32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 1));
        pending_q.push_back(mk(32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
                               32'h55555555, 32'h55555555, 32'h55555555, 1));
        wait_idle();

        // random phases over several register settings
        per_phase = ITEM_TARGET / 7;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_RADIUS, 32'd1);
                    write_reg(REG_CENTER_X, 32'h7fffffff);
                    write_reg(REG_CENTER_Y, 32'd0);
                    write_reg(REG_CENTER_Z, 32'h80000000);
                end
                1: begin
                    write_reg(REG_RADIUS, 32'h7fffffff);
                    write_reg(REG_CENTER_Y, 32'h80000000);
                end
                2: begin
                    write_reg(REG_RADIUS, 32'd0);
                    write_reg(REG_CENTER_Y, 32'h7fffffff);
                end
                default: begin
                    write_reg(REG_RADIUS, $urandom_range(ONE / 4, 8 * ONE));
                    write_reg(REG_CENTER_X, $urandom);
                    write_reg(REG_CENTER_Y, 32'(rs(20)));
                    write_reg(REG_CENTER_Z, $urandom);
                end
            endcase
            n = 0;
            while (n < per_phase) begin
                int qlen;
                qlen = $urandom_range(1, 4);
                for (int k = 0; k < qlen; k++)
                    pending_q.push_back(rand_wall(k == qlen - 1));
                n += qlen;
            end
            wait_idle();
        end

        $display("%0d walls accepted, %0d queries checked, %0d reported a collision",
                 accepted_cnt, queries_seen, hits_seen);
        $display("covered register extremes, short walls, both clamp ends and height misses");
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire
